// File: rtl/mmwi_pkg.sv
// mmwi_pkg: shared types and constants of the matrix minimum-with-index unit.
// Used by mmwi_ctrl, mmwi_dp and matrix_min_with_index_unit; no dependencies.
package mmwi_pkg;

    localparam int ELEM_W     = 32;
    localparam int POS_W      = 32;
    localparam int GRP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEADING_DIM = 3'd4;

    // element type codes
    localparam logic [2:0] ET_S8  = 3'd0;
    localparam logic [2:0] ET_S16 = 3'd1;
    localparam logic [2:0] ET_S32 = 3'd2;
    localparam logic [2:0] ET_U8  = 3'd3;
    localparam logic [2:0] ET_U16 = 3'd4;

    // reduce mode codes
    localparam logic [1:0] MODE_GLOBAL = 2'd0;
    localparam logic [1:0] MODE_COL    = 2'd1;
    localparam logic [1:0] MODE_ROW    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // element taken, row store read at cursor
        logic exec;     // compare/update, advance cursors
        logic dump_rd;  // read row store at dump index
        logic dump_out; // load one row result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;      // current element produces a column/global result
        logic row_dump;  // current element closes the matrix in row mode
        logic dump_last; // dump index is on the last row
        logic out_free;  // output register can be loaded this cycle
    } sts_t;

endpackage

// File: rtl/matrix_min_with_index_unit.sv
// matrix_min_with_index_unit: top level, joins the sequencer and the datapath.
// Depends on mmwi_pkg, mmwi_ctrl and mmwi_dp.
//
// Streams a matrix in column-major order and returns column, row or whole-matrix
// minima with their 1-based position. Each element is first accepted (and the
// row store read), then compared and updated; a result that finds the output
// register full holds the element until it drains, while a waiting result does
// not block the next element otherwise. In row mode the last element is followed
// by the row results, each read through the single read port of the row store; no
// element is taken during that dump. The row store needs no clearing after reset.
// Any register write restarts the matrix at row 0, column 0.
module matrix_min_with_index_unit #(
    parameter int MAX_ROWS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mmwi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmwi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mmwi_pkg::ELEM_W-1:0]       s_elem_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mmwi_pkg::ELEM_W-1:0]       m_min_value,
    output logic [mmwi_pkg::POS_W-1:0]        m_min_position,
    output logic [mmwi_pkg::GRP_W-1:0]        m_group_number,
    output logic                              m_last_result
);

    mmwi_pkg::cmd_t cmd;
    mmwi_pkg::sts_t sts;

    mmwi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mmwi_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_elem_value   (s_elem_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_min_value    (m_min_value),
        .m_min_position (m_min_position),
        .m_group_number (m_group_number),
        .m_last_result  (m_last_result),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// File: rtl/mmwi_ctrl.sv
// mmwi_ctrl: sequencer of the matrix minimum-with-index unit.
// Depends on mmwi_pkg (cmd_t, sts_t).
module mmwi_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mmwi_pkg::sts_t sts,
    output mmwi_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DRD  = 2'd2;
    localparam logic [1:0] S_DOUT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold while a result is due and the output register is occupied
                if (!sts.emit || sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = sts.row_dump ? S_DRD : S_IDLE;
                end
            end
            S_DRD: begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DOUT;
            end
            S_DOUT: begin
                if (sts.out_free) begin
                    cmd.dump_out = 1'b1;
                    state_next   = sts.dump_last ? S_IDLE : S_DRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_dump_rd_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dump_rd |=> (state_reg == S_DOUT))
        else $error("row store read not followed by result load");

endmodule

// File: rtl/mmwi_dp.sv
// mmwi_dp: datapath of the matrix minimum-with-index unit: configuration
// registers, cursors, compare/update, row store and output register. Uses mmwi_pkg.
module mmwi_dp #(
    parameter int MAX_ROWS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mmwi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmwi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [mmwi_pkg::ELEM_W-1:0]         s_elem_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mmwi_pkg::ELEM_W-1:0]         m_min_value,
    output logic [mmwi_pkg::POS_W-1:0]          m_min_position,
    output logic [mmwi_pkg::GRP_W-1:0]          m_group_number,
    output logic                                m_last_result,
    input  mmwi_pkg::cmd_t                      cmd,
    output mmwi_pkg::sts_t                      sts
);

    localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W  = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int ELEM_W  = mmwi_pkg::ELEM_W;
    localparam int POS_W   = mmwi_pkg::POS_W;
    localparam int GRP_W   = mmwi_pkg::GRP_W;
    localparam int STORE_W = ELEM_W + GRP_W;

    // configuration
    logic [2:0]        etype_reg;
    logic [1:0]        mode_reg;
    logic [6:0]        rowcnt_reg;
    logic [GRP_W-1:0]  colcnt_reg;
    logic [GRP_W-1:0]  ldim_reg;
    logic              cfg_hit;

    // cursors and running minimum
    logic [RIDX_W-1:0] row_cur_reg, row_cur_next;
    logic [GRP_W-1:0]  col_cur_reg, col_cur_next;
    logic [POS_W-1:0]  col_base_reg, col_base_next;
    logic [ELEM_W-1:0] run_best_reg, run_best_next;
    logic [POS_W-1:0]  run_pos_reg, run_pos_next;
    logic [ELEM_W-1:0] v_reg;
    logic [RIDX_W-1:0] dump_idx_reg, dump_idx_next;

    // row store
    logic [STORE_W-1:0] mem [MAX_ROWS];
    logic [STORE_W-1:0] rd_data_reg;
    logic               mem_rd_en;
    logic [RIDX_W-1:0]  mem_rd_addr;
    logic               mem_wr_en;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_value_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [GRP_W-1:0]  out_grp_reg;
    logic              out_last_reg;
    logic              out_load;
    logic [ELEM_W-1:0] load_value;
    logic [POS_W-1:0]  load_pos;
    logic [GRP_W-1:0]  load_grp;
    logic              load_last;

    logic [RCNT_W-1:0] rows_eff;
    logic [RCNT_W-1:0] rc_ext;
    logic [GRP_W-1:0]  cols_eff;
    logic              last_row, last_col, last_elem;
    logic              r_first, c_first;
    logic              lt_run, lt_row, upd;
    logic [ELEM_W-1:0] v_ext;
    logic [ELEM_W-1:0] row_best;
    logic [GRP_W-1:0]  row_best_col;

    function automatic logic [ELEM_W-1:0] extend(input logic [2:0] et,
                                                  input logic [ELEM_W-1:0] raw);
        logic [ELEM_W-1:0] res;
        begin
            case (et)
                mmwi_pkg::ET_S8:  res = {{24{raw[7]}}, raw[7:0]};
                mmwi_pkg::ET_S16: res = {{16{raw[15]}}, raw[15:0]};
                mmwi_pkg::ET_U8:  res = {24'd0, raw[7:0]};
                mmwi_pkg::ET_U16: res = {16'd0, raw[15:0]};
                default:          res = raw;
            endcase
            return res;
        end
    endfunction

    // strict a < b; signed types compare with the sign bit flipped
    function automatic logic less(input logic [2:0] et, input logic [ELEM_W-1:0] a,
                                  input logic [ELEM_W-1:0] b);
        logic flip;
        begin
            flip = (et <= mmwi_pkg::ET_S32);
            return {a[ELEM_W-1] ^ flip, a[ELEM_W-2:0]} < {b[ELEM_W-1] ^ flip, b[ELEM_W-2:0]};
        end
    endfunction

    assign cfg_hit = cfg_wr_en && (cfg_index <= mmwi_pkg::REG_LEADING_DIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            etype_reg  <= mmwi_pkg::ET_U16;
            mode_reg   <= mmwi_pkg::MODE_GLOBAL;
            rowcnt_reg <= 7'd1;
            colcnt_reg <= 16'd1;
            ldim_reg   <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mmwi_pkg::REG_ELEM_TYPE:   etype_reg  <= cfg_wdata[2:0];
                mmwi_pkg::REG_REDUCE_MODE: mode_reg   <= cfg_wdata[1:0];
                mmwi_pkg::REG_ROW_COUNT:   rowcnt_reg <= cfg_wdata[6:0];
                mmwi_pkg::REG_COL_COUNT:   colcnt_reg <= cfg_wdata;
                mmwi_pkg::REG_LEADING_DIM: ldim_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // effective counts: zero acts as one, rows clamp to the store depth
    always_comb begin
        rc_ext = RCNT_W'(rowcnt_reg);
        if (rc_ext == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (rc_ext > RCNT_W'(MAX_ROWS)) begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = rc_ext;
        end
        cols_eff = (colcnt_reg == '0) ? 16'd1 : colcnt_reg;
    end

    assign last_row  = (RCNT_W'(row_cur_reg) + RCNT_W'(1)) >= rows_eff;
    assign last_col  = ({1'b0, col_cur_reg} + 17'd1) >= {1'b0, cols_eff};
    assign last_elem = last_row && last_col;
    assign r_first   = (row_cur_reg == '0);
    assign c_first   = (col_cur_reg == '0);
    assign v_ext     = extend(etype_reg, s_elem_value);

    assign row_best     = rd_data_reg[STORE_W-1:GRP_W];
    assign row_best_col = rd_data_reg[GRP_W-1:0];
    assign lt_run       = less(etype_reg, v_reg, run_best_reg);
    assign lt_row       = less(etype_reg, v_reg, row_best);

    always_comb begin
        case (mode_reg)
            mmwi_pkg::MODE_GLOBAL: upd = (r_first && c_first) || lt_run;
            mmwi_pkg::MODE_COL:    upd = r_first || lt_run;
            default:               upd = 1'b0;
        endcase
    end

    assign sts.emit = ((mode_reg == mmwi_pkg::MODE_GLOBAL) && last_elem)
                   || ((mode_reg == mmwi_pkg::MODE_COL) && last_row);
    assign sts.row_dump  = (mode_reg == mmwi_pkg::MODE_ROW) && last_elem;
    assign sts.dump_last = (RCNT_W'(dump_idx_reg) + RCNT_W'(1)) >= rows_eff;
    assign sts.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        row_cur_next  = row_cur_reg;
        col_cur_next  = col_cur_reg;
        col_base_next = col_base_reg;
        run_best_next = run_best_reg;
        run_pos_next  = run_pos_reg;
        dump_idx_next = dump_idx_reg;
        if (cmd.exec) begin
            if (upd) begin
                run_best_next = v_reg;
                if (mode_reg == mmwi_pkg::MODE_GLOBAL) begin
                    run_pos_next = POS_W'(row_cur_reg) + POS_W'(1) + col_base_reg;
                end else begin
                    run_pos_next = POS_W'(row_cur_reg) + POS_W'(1);
                end
            end
            if (last_row) begin
                row_cur_next = '0;
                if (last_col) begin
                    col_cur_next  = '0;
                    col_base_next = '0;
                end else begin
                    col_cur_next  = col_cur_reg + 16'd1;
                    col_base_next = col_base_reg + POS_W'(ldim_reg);
                end
            end else begin
                row_cur_next = row_cur_reg + RIDX_W'(1);
            end
        end
        if (cmd.dump_out) begin
            dump_idx_next = sts.dump_last ? '0 : dump_idx_reg + RIDX_W'(1);
        end
        // any register write restarts the matrix
        if (cfg_hit) begin
            row_cur_next  = '0;
            col_cur_next  = '0;
            col_base_next = '0;
            run_best_next = '0;
            run_pos_next  = '0;
            dump_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cur_reg  <= '0;
            col_cur_reg  <= '0;
            col_base_reg <= '0;
            run_best_reg <= '0;
            run_pos_reg  <= '0;
            dump_idx_reg <= '0;
        end else begin
            row_cur_reg  <= row_cur_next;
            col_cur_reg  <= col_cur_next;
            col_base_reg <= col_base_next;
            run_best_reg <= run_best_next;
            run_pos_reg  <= run_pos_next;
            dump_idx_reg <= dump_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            v_reg <= v_ext;
        end
    end

    // row store: single read port, read data registered
    assign mem_rd_en   = cmd.accept || cmd.dump_rd;
    assign mem_rd_addr = cmd.dump_rd ? dump_idx_reg : row_cur_reg;
    assign mem_wr_en   = cmd.exec && (mode_reg == mmwi_pkg::MODE_ROW) && (c_first || lt_row);

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[row_cur_reg] <= {v_reg, col_cur_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // output register
    assign out_load = (cmd.exec && sts.emit) || cmd.dump_out;

    always_comb begin
        if (cmd.dump_out) begin
            load_value = row_best;
            load_pos   = POS_W'(row_best_col) + POS_W'(1);
            load_grp   = GRP_W'(dump_idx_reg);
            load_last  = sts.dump_last;
        end else begin
            load_value = run_best_next;
            load_pos   = run_pos_next;
            load_grp   = (mode_reg == mmwi_pkg::MODE_COL) ? col_cur_reg : '0;
            load_last  = last_col;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= load_value;
            out_pos_reg   <= load_pos;
            out_grp_reg   <= load_grp;
            out_last_reg  <= load_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_min_value    = out_value_reg;
    assign m_min_position = out_pos_reg;
    assign m_group_number = out_grp_reg;
    assign m_last_result  = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("output register loaded while holding an untaken result");

    a_row_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        RCNT_W'(row_cur_reg) < rows_eff)
        else $error("row cursor beyond row count");

    a_col_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_cur_reg < cols_eff)
        else $error("column cursor beyond column count");

endmodule
